@@ hdl/daq_lwd_pkg.sv @@
package daq_lwd_pkg;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_PAYLOAD  = 3'd1,
      PH_SUBHDR   = 3'd2,
      PH_SUBDATA  = 3'd3,
      PH_PAUSEVAL = 3'd4,
      PH_TRAIL    = 3'd5
   } phase_type;

   localparam logic [3:0] CLS_SECT_HDR   = 4'd0;
   localparam logic [3:0] CLS_CONFIG     = 4'd1;
   localparam logic [3:0] CLS_SUBEVT_HDR = 4'd2;
   localparam logic [3:0] CLS_SUBEVT_DAT = 4'd3;
   localparam logic [3:0] CLS_END_MARKER = 4'd4;
   localparam logic [3:0] CLS_TICK       = 4'd5;
   localparam logic [3:0] CLS_END_TEXT   = 4'd6;
   localparam logic [3:0] CLS_PAUSE      = 4'd7;
   localparam logic [3:0] CLS_SKIP       = 4'd8;
   localparam logic [3:0] CLS_TRAILING   = 4'd9;

   localparam logic [1:0] WARN_NONE       = 2'd0;
   localparam logic [1:0] WARN_UNKNOWN    = 2'd1;
   localparam logic [1:0] WARN_PAUSE_SIZE = 2'd2;
   localparam logic [1:0] WARN_AFTER_END  = 2'd3;

   localparam logic [2:0] ST_CONFIG = 3'd0;
   localparam logic [2:0] ST_EVENT  = 3'd1;
   localparam logic [2:0] ST_END    = 3'd2;
   localparam logic [2:0] ST_TICK   = 3'd3;
   localparam logic [2:0] ST_PAUSE  = 3'd4;

   localparam logic [1:0] PCODE_PAUSE  = 2'd0;
   localparam logic [1:0] PCODE_RESUME = 2'd1;
   localparam logic [1:0] PCODE_OTHER  = 2'd2;

   typedef struct packed {
      logic [3:0]  word_class;
      logic [1:0]  warning;
      logic [2:0]  section_type;
      logic [3:0]  event_type;
      logic [7:0]  module_type;
      logic [19:0] size_field;
      logic [19:0] data_index;
      logic [31:0] second_in_run;
      logic [1:0]  pause_code;
      logic [31:0] word_echo;
   } result_type;

endpackage

@@ hdl/daq_lwd_input_stage.sv @@
module daq_lwd_input_stage (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic        take,
   output logic        word_valid,
   output logic [31:0] word
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] word_ff;
   logic        load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_data_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

@@ hdl/daq_lwd_decoder.sv @@
module daq_lwd_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        wide,
   input  logic [31:0] word,
   output daq_lwd_pkg::result_type result
);

   import daq_lwd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  sect_type_ff, sect_type_in;
   logic [3:0]  evt_type_ff, evt_type_in;
   logic [7:0]  mod_type_ff, mod_type_in;
   logic [19:0] sect_left_ff, sect_left_in;
   logic [19:0] sub_left_ff, sub_left_in;
   logic [19:0] index_ff, index_in;
   logic [31:0] ticks_ff, ticks_in;

   logic [2:0]  hdr_type;
   logic [19:0] hdr_size;
   logic [3:0]  hdr_event;
   logic [7:0]  sub_module;
   logic [19:0] sub_size;
   logic [19:0] sect_dec;
   logic [19:0] sub_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         sect_type_ff <= '0;
         evt_type_ff  <= '0;
         mod_type_ff  <= '0;
         sect_left_ff <= '0;
         sub_left_ff  <= '0;
         index_ff     <= '0;
         ticks_ff     <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         sect_type_ff <= sect_type_in;
         evt_type_ff  <= evt_type_in;
         mod_type_ff  <= mod_type_in;
         sect_left_ff <= sect_left_in;
         sub_left_ff  <= sub_left_in;
         index_ff     <= index_in;
         ticks_ff     <= ticks_in;
      end
   end

   assign hdr_type   = word[31:29];
   assign hdr_size   = wide ? word[19:0] : {4'd0, word[15:0]};
   assign hdr_event  = wide ? word[28:25] : word[19:16];
   assign sub_module = wide ? word[31:24] : {2'd0, word[17:12]};
   assign sub_size   = wide ? word[19:0] : {10'd0, word[9:0]};
   assign sect_dec   = (sect_left_ff != '0) ? sect_left_ff - 20'd1 : sect_left_ff;
   assign sub_dec    = (sub_left_ff != '0) ? sub_left_ff - 20'd1 : sub_left_ff;

   always_comb begin
      phase_in     = phase_ff;
      sect_type_in = sect_type_ff;
      evt_type_in  = evt_type_ff;
      mod_type_in  = mod_type_ff;
      sect_left_in = sect_left_ff;
      sub_left_in  = sub_left_ff;
      index_in     = index_ff;
      ticks_in     = ticks_ff;

      result.word_class = CLS_SECT_HDR;
      result.warning    = WARN_NONE;
      result.event_type = '0;
      result.module_type = '0;
      result.size_field = '0;
      result.data_index = '0;
      result.pause_code = PCODE_PAUSE;

      unique case (phase_ff)
         PH_HEADER: begin
            result.word_class = CLS_SECT_HDR;
            result.size_field = hdr_size;
            sect_type_in = hdr_type;
            evt_type_in  = '0;
            mod_type_in  = '0;
            sect_left_in = hdr_size;
            if (hdr_type == ST_EVENT) begin
               evt_type_in       = hdr_event;
               result.event_type = hdr_event;
               phase_in          = PH_SUBHDR;
            end else if (hdr_type == ST_PAUSE) begin
               if (hdr_size == 20'd1) begin
                  phase_in = PH_PAUSEVAL;
               end else begin
                  result.warning = WARN_PAUSE_SIZE;
                  phase_in = (hdr_size != '0) ? PH_PAYLOAD : PH_HEADER;
               end
            end else begin
               if (hdr_type == ST_TICK && ticks_ff != '1) begin
                  ticks_in = ticks_ff + 32'd1;
               end
               if (hdr_type > ST_PAUSE) begin
                  result.warning = WARN_UNKNOWN;
               end
               if (hdr_size != '0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = (hdr_type == ST_END) ? PH_TRAIL : PH_HEADER;
               end
            end
         end
         PH_PAYLOAD: begin
            unique case (sect_type_ff)
               ST_CONFIG: result.word_class = CLS_CONFIG;
               ST_END:    result.word_class = CLS_END_TEXT;
               ST_TICK:   result.word_class = CLS_TICK;
               default:   result.word_class = CLS_SKIP;
            endcase
            sect_left_in = sect_dec;
            if (sect_dec == '0) begin
               phase_in = (sect_type_ff == ST_END) ? PH_TRAIL : PH_HEADER;
            end
         end
         PH_SUBHDR: begin
            result.event_type = evt_type_ff;
            if (sect_left_ff > 20'd1) begin
               result.word_class  = CLS_SUBEVT_HDR;
               result.module_type = sub_module;
               result.size_field  = sub_size;
               sect_left_in = sect_left_ff - 20'd1;
               mod_type_in  = sub_module;
               sub_left_in  = sub_size;
               index_in     = '0;
               if (sub_size != '0) begin
                  phase_in = PH_SUBDATA;
               end
            end else begin
               result.word_class = CLS_END_MARKER;
               sect_left_in = '0;
               phase_in     = PH_HEADER;
            end
         end
         PH_SUBDATA: begin
            result.word_class  = CLS_SUBEVT_DAT;
            result.event_type  = evt_type_ff;
            result.module_type = mod_type_ff;
            result.data_index  = index_ff;
            index_in     = index_ff + 20'd1;
            sect_left_in = sect_dec;
            sub_left_in  = sub_dec;
            if (sub_dec == '0) begin
               phase_in = PH_SUBHDR;
            end
         end
         PH_PAUSEVAL: begin
            result.word_class = CLS_PAUSE;
            if (word == 32'd0) begin
               result.pause_code = PCODE_PAUSE;
            end else if (word == 32'd1) begin
               result.pause_code = PCODE_RESUME;
            end else begin
               result.pause_code = PCODE_OTHER;
            end
            sect_left_in = '0;
            phase_in     = PH_HEADER;
         end
         default: begin
            result.word_class = CLS_TRAILING;
            result.warning    = WARN_AFTER_END;
            sect_type_in = ST_END;
            phase_in     = PH_TRAIL;
         end
      endcase

      result.section_type  = sect_type_in;
      result.second_in_run = ticks_in;
      result.word_echo     = word;
   end

endmodule

@@ hdl/daq_lwd_output_stage.sv @@
module daq_lwd_output_stage (
   input  logic clock,
   input  logic reset,
   input  logic result_valid,
   input  daq_lwd_pkg::result_type result,
   output logic load_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output daq_lwd_pkg::result_type rsp_result
);

   import daq_lwd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   logic       load;

   assign load_ready = !valid_ff || rsp_ready;
   assign load       = result_valid && load_ready;
   assign valid_in   = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

@@ hdl/daq_listfile_word_deframer_top.sv @@
// Listfile word deframer.
// The req channel carries one 32-bit stream word per transaction, starting
// at the first section header. The rsp channel returns one classified
// result per word, in order, with the word echoed back.
// The csr port writes the one-bit format version whenever csr_we is high;
// it should only change while no transaction is in flight.
// A word taken on req passes through the input register and then the result
// register before it is offered on rsp. One word per cycle is sustained
// while rsp_ready stays high: each word is classified by short logic between
// the input register and the result register, with the framing state
// updated in the same cycle.
// When the receiver stalls, the result register holds its transaction and
// the input register still takes one more word; req_ready drops only when
// both are full.
// Synchronous reset empties both registers, returns the framer to expecting
// a section header, clears the tick count and sets the wide layout.
module daq_listfile_word_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_word_class,
   output logic [1:0]  rsp_warning,
   output logic [2:0]  rsp_section_type,
   output logic [3:0]  rsp_event_type,
   output logic [7:0]  rsp_module_type,
   output logic [19:0] rsp_size_field,
   output logic [19:0] rsp_data_index,
   output logic [31:0] rsp_second_in_run,
   output logic [1:0]  rsp_pause_code,
   output logic [31:0] rsp_word_echo,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   import daq_lwd_pkg::*;

   logic        version_ff;
   logic        version_in;
   logic        word_valid;
   logic [31:0] word;
   logic        load_ready;
   logic        step;
   result_type  result;
   result_type  rsp_result;

   assign version_in = csr_we ? csr_wdata : version_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 1'b1;
      end else begin
         version_ff <= version_in;
      end
   end

   assign step = word_valid && load_ready;

   daq_lwd_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_word (req_data_word),
      .take          (step),
      .word_valid    (word_valid),
      .word          (word)
   );

   daq_lwd_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .wide   (version_ff),
      .word   (word),
      .result (result)
   );

   daq_lwd_output_stage u_output (
      .clock        (clock),
      .reset        (reset),
      .result_valid (word_valid),
      .result       (result),
      .load_ready   (load_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_result   (rsp_result)
   );

   assign rsp_word_class    = rsp_result.word_class;
   assign rsp_warning       = rsp_result.warning;
   assign rsp_section_type  = rsp_result.section_type;
   assign rsp_event_type    = rsp_result.event_type;
   assign rsp_module_type   = rsp_result.module_type;
   assign rsp_size_field    = rsp_result.size_field;
   assign rsp_data_index    = rsp_result.data_index;
   assign rsp_second_in_run = rsp_result.second_in_run;
   assign rsp_pause_code    = rsp_result.pause_code;
   assign rsp_word_echo     = rsp_result.word_echo;

endmodule
